### hw/rtl/pana_pkg.sv
// ============================================================================
// pana_pkg
// Shared constants, types and address helpers for the pad ADC noise
// accumulator: channel geometry, field widths, store entry layout and the
// command and status bundles between controller and datapath.
// ============================================================================
package pana_pkg;

    localparam int NUM_SECTORS           = 18;
    localparam int NUM_LAYERS            = 6;
    localparam int ROWS_LONG_STACK       = 16;
    localparam int ROWS_SHORT_STACK      = 12;
    localparam int MCM_COLUMNS_PER_BOARD = 4;
    localparam int ADCS_PER_MCM          = 21;

    localparam int NUM_STACKS         = 5;
    localparam int SHORT_STACK        = 2;
    localparam int CHAMBERS_PER_SECT  = NUM_STACKS * NUM_LAYERS;
    localparam int PER_ROW            = 2 * MCM_COLUMNS_PER_BOARD * ADCS_PER_MCM;
    localparam int PER_LONG           = ROWS_LONG_STACK * PER_ROW;
    localparam int PER_SHORT          = ROWS_SHORT_STACK * PER_ROW;
    localparam int PER_LAYER          = (NUM_STACKS - 1) * PER_LONG + PER_SHORT;
    localparam int PER_SECTOR         = NUM_LAYERS * PER_LAYER;
    localparam int TOTAL_CHANNELS     = NUM_SECTORS * PER_SECTOR;

    // detector / 30 as (detector * 2185) >> 16, exact for 10-bit detector
    localparam int SECT_RECIP = 2185;
    localparam int SECT_SHIFT = 16;

    localparam int MODE_W   = 1;
    localparam int DET_W    = 10;
    localparam int ROW_W    = 4;
    localparam int ROB_W    = 3;
    localparam int MCM_W    = 4;
    localparam int CH_W     = 5;
    localparam int SMP_W    = 10;
    localparam int IDX_W    = 21;
    localparam int CNT_W    = 32;
    localparam int SUM_W    = 42;
    localparam int SQ_W     = 52;
    localparam int SECT_W   = 6;
    localparam int REM_W    = 5;
    localparam int STK_W    = 3;
    localparam int LAY_W    = 3;
    localparam int COL_W    = 4;
    localparam int CHAN_W   = 8;
    localparam int LOCAL_W  = 12;
    localparam int PART_W   = 17;
    localparam int PROD_W   = DET_W + 12;
    localparam int WIDE_W   = 23;
    localparam int SMPSQ_W  = 2 * SMP_W;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 152;

    localparam logic MODE_ACCUM = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic             seen;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sum_sq;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP1,
        ST_MAP2,
        ST_SUM1,
        ST_SUM2,
        ST_READ,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic map1;
        logic map2;
        logic sum1;
        logic sum2;
        logic rd_en;
        logic commit;
        logic clr_en;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_sts;

    function automatic logic [STK_W-1:0] f_stack(input logic [REM_W-1:0] rem);
        logic [STK_W-1:0] stk;
        stk = '0;
        for (int k = 1; k < NUM_STACKS; k++) begin
            if (rem >= REM_W'(k * NUM_LAYERS)) begin
                stk = STK_W'(k);
            end
        end
        return stk;
    endfunction

endpackage

### hw/rtl/pana_ram.sv
// ============================================================================
// pana_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module pana_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/pana_ctrl.sv
// ============================================================================
// pana_ctrl
// Controller: clearing pass after reset, then one request at a time through
// address mapping, store read and commit.
// ============================================================================
module pana_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pana_pkg::t_sts i_sts,
    output pana_pkg::t_cmd o_cmd
);
    import pana_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (i_sts.clr_last) n_state = ST_IDLE;
            ST_IDLE:   if (i_in_valid) n_state = ST_MAP1;
            ST_MAP1:   n_state = ST_MAP2;
            ST_MAP2:   n_state = ST_SUM1;
            ST_SUM1:   n_state = ST_SUM2;
            ST_SUM2:   n_state = ST_READ;
            ST_READ:   n_state = ST_COMMIT;
            ST_COMMIT: if (i_sts.out_free) n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR:  o_cmd.clr_en = 1'b1;
            ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load_in  = i_in_valid;
            end
            ST_MAP1:   o_cmd.map1 = 1'b1;
            ST_MAP2:   o_cmd.map2 = 1'b1;
            ST_SUM1:   o_cmd.sum1 = 1'b1;
            ST_SUM2:   o_cmd.sum2 = 1'b1;
            ST_READ:   o_cmd.rd_en = 1'b1;
            ST_COMMIT: o_cmd.commit = i_sts.out_free;
            default:   o_cmd = '0;
        endcase
    end

    a_commit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT && !i_sts.out_free) |=> (r_state == ST_COMMIT))
        else $error("commit left while output register full");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (!o_in_ready && !o_cmd.load_in))
        else $error("transfer accepted during clearing pass");

    a_read_then_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |=> (r_state == ST_COMMIT))
        else $error("store read not followed by commit");

endmodule

### hw/rtl/pana_dp.sv
// ============================================================================
// pana_dp
// Datapath: address mapping to global channel index, statistics store,
// saturating update and output register.
// ============================================================================
module pana_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pana_pkg::t_cmd                 i_cmd,
    output pana_pkg::t_sts                 o_sts,
    input  logic [pana_pkg::MODE_W-1:0]    i_mode,
    input  logic [pana_pkg::DET_W-1:0]     i_detector,
    input  logic [pana_pkg::ROW_W-1:0]     i_pad_row,
    input  logic [pana_pkg::ROB_W-1:0]     i_readout_board,
    input  logic [pana_pkg::MCM_W-1:0]     i_mcm,
    input  logic [pana_pkg::CH_W-1:0]      i_adc_channel,
    input  logic [pana_pkg::SMP_W-1:0]     i_adc_sample,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic                           o_status,
    output logic [pana_pkg::IDX_W-1:0]     o_channel_index,
    output pana_pkg::t_entry               o_entry
);
    import pana_pkg::*;

    logic [MODE_W-1:0]  r_mode;
    logic [DET_W-1:0]   r_det;
    logic [ROW_W-1:0]   r_row;
    logic [ROB_W-1:0]   r_rob;
    logic [MCM_W-1:0]   r_mcm;
    logic [CH_W-1:0]    r_ch;
    logic [SMP_W-1:0]   r_sample;

    logic [SECT_W-1:0]  r_sector;
    logic [SMPSQ_W-1:0] r_smp_sq;
    logic [STK_W-1:0]   r_stack;
    logic [LAY_W-1:0]   r_layer;
    logic [LOCAL_W-1:0] r_local;
    logic               r_ok;
    logic [PART_W-1:0]  r_part;
    logic [IDX_W-1:0]   r_index;
    logic [IDX_W-1:0]   r_clr_addr;

    logic               r_out_valid;
    logic               r_out_status;
    logic [IDX_W-1:0]   r_out_index;
    t_entry             r_out_entry;

    logic [PROD_W-1:0]  n_sect_prod;
    logic [10:0]        n_rem_full;
    logic [REM_W-1:0]   n_rem;
    logic [STK_W-1:0]   n_stack;
    logic [LAY_W-1:0]   n_layer;
    logic [ROW_W:0]     n_rows;
    logic [COL_W-1:0]   n_mcmcol;
    logic [CHAN_W-1:0]  n_chan;
    logic               n_ok;
    logic [PART_W-1:0]  n_stack_off;
    logic [WIDE_W-1:0]  n_index;

    t_entry             w_rdata;
    t_entry             n_entry;
    logic [CNT_W:0]     n_cnt_add;
    logic [SUM_W:0]     n_sum_add;
    logic [SQ_W:0]      n_sq_add;

    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    t_entry             w_wdata;

    assign n_sect_prod = PROD_W'(r_det) * PROD_W'(SECT_RECIP);
    assign n_rem_full  = 11'(r_det) - 11'(r_sector) * 11'(CHAMBERS_PER_SECT);
    assign n_rem       = n_rem_full[REM_W-1:0];
    assign n_stack     = f_stack(n_rem);
    assign n_layer     = LAY_W'(n_rem - REM_W'(n_stack) * REM_W'(NUM_LAYERS));
    assign n_rows      = (n_stack == STK_W'(SHORT_STACK)) ? (ROW_W+1)'(ROWS_SHORT_STACK)
                                                          : (ROW_W+1)'(ROWS_LONG_STACK);
    assign n_mcmcol    = COL_W'(r_mcm % MCM_W'(MCM_COLUMNS_PER_BOARD))
                       + (r_rob[0] ? COL_W'(MCM_COLUMNS_PER_BOARD) : COL_W'(0));
    assign n_chan      = CHAN_W'(n_mcmcol) * CHAN_W'(ADCS_PER_MCM)
                       + CHAN_W'(ADCS_PER_MCM - 1) - CHAN_W'(r_ch);
    assign n_ok        = (r_sector < SECT_W'(NUM_SECTORS))
                       && ((ROW_W+1)'(r_row) < n_rows)
                       && (r_ch < CH_W'(ADCS_PER_MCM));

    assign n_stack_off = (r_stack <= STK_W'(SHORT_STACK))
                       ? PART_W'(r_stack) * PART_W'(PER_LONG)
                       : PART_W'(r_stack - STK_W'(1)) * PART_W'(PER_LONG) + PART_W'(PER_SHORT);
    assign n_index     = WIDE_W'(r_sector) * WIDE_W'(PER_SECTOR) + WIDE_W'(r_part);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode   <= i_mode;
            r_det    <= i_detector;
            r_row    <= i_pad_row;
            r_rob    <= i_readout_board;
            r_mcm    <= i_mcm;
            r_ch     <= i_adc_channel;
            r_sample <= i_adc_sample;
        end
        if (i_cmd.map1) begin
            r_sector <= n_sect_prod[SECT_SHIFT +: SECT_W];
            r_smp_sq <= SMPSQ_W'(r_sample) * SMPSQ_W'(r_sample);
        end
        if (i_cmd.map2) begin
            r_stack <= n_stack;
            r_layer <= n_layer;
            r_ok    <= n_ok;
            r_local <= LOCAL_W'(r_row) * LOCAL_W'(PER_ROW) + LOCAL_W'(n_chan);
        end
        if (i_cmd.sum1) begin
            r_part <= PART_W'(r_layer) * PART_W'(PER_LAYER) + n_stack_off + PART_W'(r_local);
        end
        if (i_cmd.sum2) begin
            r_index <= n_index[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en && !o_sts.clr_last) begin
            r_clr_addr <= r_clr_addr + IDX_W'(1);
        end
    end

    pana_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TOTAL_CHANNELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en && r_ok),
        .i_raddr (r_index),
        .o_rdata (w_rdata)
    );

    assign n_cnt_add = (CNT_W+1)'(w_rdata.count) + (CNT_W+1)'(1);
    assign n_sum_add = (SUM_W+1)'(w_rdata.sum) + (SUM_W+1)'(r_sample);
    assign n_sq_add  = (SQ_W+1)'(w_rdata.sum_sq) + (SQ_W+1)'(r_smp_sq);

    always_comb begin
        n_entry.seen   = 1'b1;
        n_entry.count  = n_cnt_add[CNT_W] ? '1 : n_cnt_add[CNT_W-1:0];
        n_entry.sum    = n_sum_add[SUM_W] ? '1 : n_sum_add[SUM_W-1:0];
        n_entry.sum_sq = n_sq_add[SQ_W]   ? '1 : n_sq_add[SQ_W-1:0];
    end

    assign w_we    = i_cmd.clr_en || (i_cmd.commit && r_ok && (r_mode == MODE_ACCUM));
    assign w_waddr = i_cmd.clr_en ? r_clr_addr : r_index;
    assign w_wdata = i_cmd.clr_en ? t_entry'('0) : n_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (!r_ok) begin
                r_out_status <= STATUS_ERR;
                r_out_index  <= '0;
                r_out_entry  <= '0;
            end else begin
                r_out_status <= STATUS_OK;
                r_out_index  <= r_index;
                r_out_entry  <= (r_mode == MODE_ACCUM) ? n_entry : w_rdata;
            end
        end
    end

    assign o_sts.clr_last = (r_clr_addr == IDX_W'(TOTAL_CHANNELS - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_channel_index = r_out_index;
    assign o_entry         = r_out_entry;

    a_commit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("commit did not load output register");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == STATUS_ERR) |-> (r_out_index == '0 && r_out_entry == '0))
        else $error("error result carries nonzero data");

    a_clr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_addr < IDX_W'(TOTAL_CHANNELS))
        else $error("clear address beyond store depth");

endmodule

### hw/rtl/per_pad_adc_noise_accumulator_top.sv
// ============================================================================
// per_pad_adc_noise_accumulator_top
// Per-channel count, sum and sum of squares of ADC samples, addressed by
// chamber, pad row, readout board, MCM and ADC channel.
//
//   Channel   Dir  Fields
//   s_axis    in   tuser: mode; tdata: detector, pad_row, readout_board,
//                  mcm, adc_channel, adc_sample
//   m_axis    out  tuser: status; tdata: channel_index, channel_seen,
//                  sample_count, sample_sum, sample_sum_squares
//
// Each request passes through four address-mapping stages, the store read
// with registered data, and the commit; the next request is taken only after
// its commit.
// After reset a clearing pass zeroes the store, all 1378944 entries, one
// entry a cycle; no input is taken until it ends.
// A result waits in the output register; the next request is taken meanwhile
// and its commit holds until the register is free.
// ============================================================================
module per_pad_adc_noise_accumulator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // detector[9:0], pad_row[13:10], readout_board[16:14], mcm[20:17],
    // adc_channel[25:21], adc_sample[35:26], zero[39:36]
    input  logic [pana_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // mode[0]
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // channel_index[20:0], channel_seen[21], sample_count[53:22],
    // sample_sum[95:54], sample_sum_squares[147:96], zero[151:148]
    output logic [pana_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // status[0]
    output logic                            o_m_axis_tuser
);
    import pana_pkg::*;

    t_cmd             w_cmd;
    t_sts             w_sts;
    logic             w_status;
    logic [IDX_W-1:0] w_index;
    t_entry           w_entry;

    pana_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pana_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_mode          (i_s_axis_tuser),
        .i_detector      (i_s_axis_tdata[9:0]),
        .i_pad_row       (i_s_axis_tdata[13:10]),
        .i_readout_board (i_s_axis_tdata[16:14]),
        .i_mcm           (i_s_axis_tdata[20:17]),
        .i_adc_channel   (i_s_axis_tdata[25:21]),
        .i_adc_sample    (i_s_axis_tdata[35:26]),
        .i_out_ready     (i_m_axis_tready),
        .o_out_valid     (o_m_axis_tvalid),
        .o_status        (w_status),
        .o_channel_index (w_index),
        .o_entry         (w_entry)
    );

    assign o_m_axis_tuser = w_status;
    assign o_m_axis_tdata = {4'b0000, w_entry.sum_sq, w_entry.sum, w_entry.count,
                             w_entry.seen, w_index};

endmodule

### tb/per_pad_adc_noise_accumulator_top_tb.sv
// ----------------------------------------------------------------------------
// per_pad_adc_noise_accumulator_top_tb
// Self-checking bench for the per-pad ADC noise accumulator. Requests go in
// on the slave stream, and a scoreboard keeps its own per-channel count, sum
// and sum of squares. Every result on the master stream is compared against
// the oldest expectation. The run starts with directed address corners and
// then sends random traffic that keeps returning to a few channels. Both
// sides stall in bursts.
// ----------------------------------------------------------------------------
module per_pad_adc_noise_accumulator_top_tb;
    import pana_pkg::*;

    localparam int CYCLE_LIMIT  = 6_000_000;
    localparam int RANDOM_ITEMS = 730;
    localparam int CALM_AFTER   = 640;
    localparam int POOL_SIZE    = 6;
    localparam int SEEN_BIT     = IDX_W;
    localparam int CNT_LO       = IDX_W + 1;
    localparam int SUM_LO       = CNT_LO + CNT_W;
    localparam int SQ_LO        = SUM_LO + SUM_W;

    typedef struct packed {
        logic [DET_W-1:0] detector;
        logic [ROW_W-1:0] pad_row;
        logic [ROB_W-1:0] readout_board;
        logic [MCM_W-1:0] mcm;
        logic [CH_W-1:0]  adc_channel;
    } t_pad_addr;

    localparam int ADDR_BITS = $bits(t_pad_addr);

    typedef struct packed {
        logic             status;
        logic [IDX_W-1:0] index;
        logic             seen;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sum_sq;
    } t_chan_stats;

    class channel_stats_book;
        t_chan_stats      awaited[$];
        bit               seen_tab[int unsigned];
        logic [CNT_W-1:0] count_tab[int unsigned];
        logic [SUM_W-1:0] sum_tab[int unsigned];
        logic [SQ_W-1:0]  sq_tab[int unsigned];
        int               mismatches;
        int               requests;
        int               out_of_range;
        int               reads;

        function bit map_channel(input t_pad_addr a, output int unsigned idx);
            int unsigned sector, layer, stack, rows, mcmcol, chan, stack_off;
            sector = a.detector / CHAMBERS_PER_SECT;
            layer  = a.detector % NUM_LAYERS;
            stack  = (a.detector % CHAMBERS_PER_SECT) / NUM_LAYERS;
            rows   = (stack == SHORT_STACK) ? ROWS_SHORT_STACK : ROWS_LONG_STACK;
            idx    = 0;
            if (sector >= NUM_SECTORS || a.pad_row >= rows || a.adc_channel >= ADCS_PER_MCM) begin
                return 1'b0;
            end
            mcmcol = a.mcm % MCM_COLUMNS_PER_BOARD;
            if (a.readout_board[0]) begin
                mcmcol += MCM_COLUMNS_PER_BOARD;
            end
            chan = mcmcol * ADCS_PER_MCM + (ADCS_PER_MCM - 1) - a.adc_channel;
            stack_off = (stack <= SHORT_STACK) ? stack * PER_LONG
                                               : (stack - 1) * PER_LONG + PER_SHORT;
            idx = sector * PER_SECTOR + layer * PER_LAYER + stack_off
                  + a.pad_row * PER_ROW + chan;
            return idx < TOTAL_CHANNELS;
        endfunction

        function void note_request(input t_pad_addr a, input logic mode,
                                   input logic [SMP_W-1:0] smp);
            t_chan_stats    e;
            int unsigned    idx;
            logic [SUM_W:0] s;
            logic [SQ_W:0]  q;
            requests++;
            if (mode == MODE_READ) begin
                reads++;
            end
            e = '0;
            if (!map_channel(a, idx)) begin
                out_of_range++;
                e.status = STATUS_ERR;
            end else begin
                if (!count_tab.exists(idx)) begin
                    seen_tab[idx]  = 1'b0;
                    count_tab[idx] = '0;
                    sum_tab[idx]   = '0;
                    sq_tab[idx]    = '0;
                end
                if (mode == MODE_ACCUM) begin
                    if (count_tab[idx] != '1) begin
                        count_tab[idx] = count_tab[idx] + 1'b1;
                    end
                    s = {1'b0, sum_tab[idx]} + smp;
                    sum_tab[idx] = s[SUM_W] ? '1 : s[SUM_W-1:0];
                    q = {1'b0, sq_tab[idx]} + smp * smp;
                    sq_tab[idx] = q[SQ_W] ? '1 : q[SQ_W-1:0];
                    seen_tab[idx] = 1'b1;
                end
                e.status = STATUS_OK;
                e.index  = idx[IDX_W-1:0];
                e.seen   = seen_tab[idx];
                e.count  = count_tab[idx];
                e.sum    = sum_tab[idx];
                e.sum_sq = sq_tab[idx];
            end
            awaited = {awaited, e};
        endfunction

        function void check_result(input logic status, input logic [OUT_DATA_W-1:0] d);
            t_chan_stats e, got;
            got.status = status;
            got.index  = d[0 +: IDX_W];
            got.seen   = d[SEEN_BIT];
            got.count  = d[CNT_LO +: CNT_W];
            got.sum    = d[SUM_LO +: SUM_W];
            got.sum_sq = d[SQ_LO +: SQ_W];
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result with nothing awaited: st=%0d idx=%0d cnt=%0d",
                             got.status, got.index, got.count);
                end
                return;
            end
            e = awaited.pop_front();
            if (got.status !== e.status || got.index !== e.index || got.seen !== e.seen ||
                got.count !== e.count || got.sum !== e.sum || got.sum_sq !== e.sum_sq) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: exp st=%0d idx=%0d seen=%0d cnt=%0d sum=%0d sq=%0d",
                             e.status, e.index, e.seen, e.count, e.sum, e.sum_sq);
                    $display("       got st=%0d idx=%0d seen=%0d cnt=%0d sum=%0d sq=%0d",
                             got.status, got.index, got.seen, got.count, got.sum, got.sum_sq);
                end
            end
        endfunction
    endclass

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    channel_stats_book book = new();
    bit                calm = 1'b0;
    int                stall_left = 0;
    int                cycle_cnt = 0;
    t_pad_addr         pool[POOL_SIZE];

    per_pad_adc_noise_accumulator_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, book.awaited.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // hold off the result stream in random bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            book.check_result(m_tuser, m_tdata);
        end
    end

    task automatic send_request(input logic mode, input t_pad_addr a,
                                input logic [SMP_W-1:0] smp);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(IN_DATA_W - 36){1'b0}}, smp, a.adc_channel, a.mcm,
                     a.readout_board, a.pad_row, a.detector};
        do @(posedge i_clk); while (!s_tready);
        book.note_request(a, mode, smp);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic send_fields(input logic mode, input int det, input int row,
                               input int rob, input int mcm, input int ch, input int smp);
        t_pad_addr a;
        a.detector      = DET_W'(det);
        a.pad_row       = ROW_W'(row);
        a.readout_board = ROB_W'(rob);
        a.mcm           = MCM_W'(mcm);
        a.adc_channel   = CH_W'(ch);
        send_request(mode, a, SMP_W'(smp));
    endtask

    function automatic t_pad_addr pick_valid_addr();
        t_pad_addr   a;
        int unsigned stack;
        a.detector      = DET_W'($urandom_range(0, NUM_SECTORS * CHAMBERS_PER_SECT - 1));
        stack           = (a.detector % CHAMBERS_PER_SECT) / NUM_LAYERS;
        a.pad_row       = ROW_W'($urandom_range(0, (stack == SHORT_STACK)
                                                   ? ROWS_SHORT_STACK - 1
                                                   : ROWS_LONG_STACK - 1));
        a.readout_board = ROB_W'($urandom_range(0, 7));
        a.mcm           = MCM_W'($urandom_range(0, 15));
        a.adc_channel   = CH_W'($urandom_range(0, ADCS_PER_MCM - 1));
        return a;
    endfunction

    initial begin
        t_pad_addr        a;
        logic             mode;
        logic [SMP_W-1:0] smp;
        int unsigned      r;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        send_fields(MODE_READ,     0,  0, 0,  0,  0,    0);
        send_fields(MODE_ACCUM,    0,  0, 0,  0,  0, 1023);
        send_fields(MODE_ACCUM,    0,  0, 0,  0,  0,    0);
        send_fields(MODE_READ,     0,  0, 0,  0,  0,  555);
        send_fields(MODE_ACCUM,  539, 15, 7, 15, 20, 1023);
        send_fields(MODE_READ,   539, 15, 7, 15, 20,    0);
        send_fields(MODE_ACCUM,  540,  0, 0,  0,  0,  100);
        send_fields(MODE_ACCUM, 1023, 15, 7, 15, 31, 1023);
        send_fields(MODE_ACCUM,   12, 11, 2,  1,  5,  300);
        send_fields(MODE_ACCUM,   12, 12, 2,  1,  5,  300);
        send_fields(MODE_ACCUM,   17, 15, 0,  0,  0,  200);
        send_fields(MODE_ACCUM,    6,  3, 4,  2, 21,  400);
        send_fields(MODE_READ,     6,  3, 4,  2, 31,  400);
        send_fields(MODE_ACCUM,    1,  2, 1,  3,  0,  512);
        send_fields(MODE_ACCUM,    1,  2, 6,  4, 10,    1);
        send_fields(MODE_ACCUM,   17,  0, 3,  7, 20,  682);
        send_fields(MODE_ACCUM,   18, 15, 5, 12,  9,  341);
        send_fields(MODE_READ,    18, 15, 5, 12,  9,    0);
        repeat (3) send_fields(MODE_ACCUM, 300, 7, 2, 9, 14, 1023);
        send_fields(MODE_READ,   300,  7, 2,  9, 14, 1023);

        foreach (pool[k]) begin
            pool[k] = pick_valid_addr();
        end

        // random traffic, mostly revisiting a small pool of channels
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == CALM_AFTER) begin
                calm = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 55) begin
                a = pool[$urandom_range(0, POOL_SIZE - 1)];
            end else if (r < 85) begin
                a = pick_valid_addr();
                if ($urandom_range(0, 2) == 0) begin
                    pool[$urandom_range(0, POOL_SIZE - 1)] = a;
                end
            end else begin
                a = ADDR_BITS'($urandom());
            end
            mode = ($urandom_range(0, 3) == 0) ? MODE_READ : MODE_ACCUM;
            smp  = ($urandom_range(0, 9) == 0) ? {SMP_W{1'b1}} : SMP_W'($urandom());
            send_request(mode, a, smp);
        end
        s_tvalid <= 1'b0;

        while (book.awaited.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d requests: %0d reads, %0d out of range, %0d channels touched",
                 book.requests, book.reads, book.out_of_range, book.count_tab.num());
        $display("Mismatches: %0d", book.mismatches);
        if (book.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
